// ===== sv/scea_pkg.sv =====
// ----------------------------------------------------------------------------
// scea_pkg
// Shared types and constants for the stick command encoder with arming.
// ----------------------------------------------------------------------------
package scea_pkg;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THR_CENTER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_CENTER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_CENTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_CENTER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GESTURE_THR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_HOLD     = 3'd5;

  localparam logic [11:0] CENTER_RST  = 12'd2048;
  localparam logic [11:0] GESTURE_RST = 12'd900;
  localparam logic [15:0] CAL_HOLD_RST = 16'd3000;

  localparam logic signed [12:0] AX_DEADBAND = 13'sd40;
  localparam logic signed [12:0] AX_CLAMP    = 13'sd1800;
  localparam logic signed [12:0] THR_LOW_CUT = 13'sd120;

  localparam logic [31:0] LOCKOUT_MS = 32'd250;
  localparam logic [31:0] GRACE_MS   = 32'd300;
  localparam logic [31:0] SEND_MS    = 32'd20;

  // floor(x / 18) = (x * RECIP_18) >> RECIP_SHIFT for x below 2^18 / 8
  localparam logic [14:0] RECIP_18    = 15'd14564;
  localparam int          RECIP_SHIFT = 18;

  typedef struct packed {
    logic [11:0] thr_center;
    logic [11:0] yaw_center;
    logic [11:0] pitch_center;
    logic [11:0] roll_center;
    logic [11:0] gesture_thr;
    logic [15:0] cal_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic [11:0] roll_raw;
    logic [11:0] pitch_raw;
    logic [11:0] yaw_raw;
    logic [11:0] throttle_raw;
    logic        right_switch;
    logic        left_switch;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [4:0]        pad;
    logic              send_packet;
    logic signed [9:0] roll_cmd;
    logic signed [9:0] pitch_cmd;
    logic signed [9:0] yaw_cmd;
    logic [9:0]        throttle_cmd;
    logic              cal_level;
    logic              armed_flag;
  } out_item_t;

  typedef struct packed {
    logic armed;
    logic cal;
    logic thr_zero;
    logic send;
  } ctl_t;

endpackage

// ===== sv/scea_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// scea_cfg_regs
// Configuration register file: stick centers, gesture threshold, hold time.
// ----------------------------------------------------------------------------
module scea_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scea_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scea_pkg::CFG_DATA_W-1:0]   cfg_data,
  output scea_pkg::cfg_t                    cfg
);
  import scea_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_THR_CENTER:   cfg_nxt.thr_center   = cfg_data[11:0];
        REG_YAW_CENTER:   cfg_nxt.yaw_center   = cfg_data[11:0];
        REG_PITCH_CENTER: cfg_nxt.pitch_center = cfg_data[11:0];
        REG_ROLL_CENTER:  cfg_nxt.roll_center  = cfg_data[11:0];
        REG_GESTURE_THR:  cfg_nxt.gesture_thr  = cfg_data[11:0];
        REG_CAL_HOLD:     cfg_nxt.cal_hold_ms  = cfg_data[15:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr_center   <= CENTER_RST;
      cfg_r.yaw_center   <= CENTER_RST;
      cfg_r.pitch_center <= CENTER_RST;
      cfg_r.roll_center  <= CENTER_RST;
      cfg_r.gesture_thr  <= GESTURE_RST;
      cfg_r.cal_hold_ms  <= CAL_HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== sv/scea_stick_map.sv =====
// ----------------------------------------------------------------------------
// scea_stick_map
// Maps raw stick readings to throttle and signed axis commands.
// ----------------------------------------------------------------------------
module scea_stick_map (
  input  logic              [11:0] throttle_raw,
  input  logic              [11:0] yaw_raw,
  input  logic              [11:0] pitch_raw,
  input  logic              [11:0] roll_raw,
  input  scea_pkg::cfg_t           cfg,
  output logic              [9:0]  throttle_cmd,
  output logic signed       [9:0]  yaw_cmd,
  output logic signed       [9:0]  pitch_cmd,
  output logic signed       [9:0]  roll_cmd
);
  import scea_pkg::*;

  // x * 5 / 18 is done by the caller as x5 / 18
  function automatic logic [9:0] div18(input logic [14:0] x);
    logic [29:0] p;
    p = 30'(x) * 30'(RECIP_18);
    return p[RECIP_SHIFT+9:RECIP_SHIFT];
  endfunction

  function automatic logic signed [9:0] map_axis(input logic [11:0] raw,
                                                 input logic [11:0] ctr,
                                                 input logic        inv);
    logic signed [12:0] v;
    logic [10:0]        mag;
    logic [13:0]        x;
    logic [9:0]         q;
    logic               neg;
    v   = $signed({1'b0, raw}) - $signed({1'b0, ctr});
    neg = v[12] ^ inv;
    if (v > -AX_DEADBAND && v < AX_DEADBAND) begin
      mag = 11'd0;
    end else if (v > AX_CLAMP || v < -AX_CLAMP) begin
      mag = 11'(AX_CLAMP);
    end else if (v[12]) begin
      mag = 11'(-v);
    end else begin
      mag = 11'(v);
    end
    x = {1'b0, mag, 2'b00} + {3'b000, mag};
    q = div18({1'b0, x});
    return neg ? -$signed(q) : $signed(q);
  endfunction

  logic signed [12:0] thr_v;
  logic signed [12:0] thr_vc;
  logic [11:0]        thr_u;
  logic [14:0]        thr_x;

  always_comb begin
    thr_v = $signed({1'b0, throttle_raw}) - $signed({1'b0, cfg.thr_center});
    if (thr_v > AX_CLAMP) begin
      thr_vc = AX_CLAMP;
    end else if (thr_v < -AX_CLAMP) begin
      thr_vc = -AX_CLAMP;
    end else begin
      thr_vc = thr_v;
    end
    thr_u = 12'(thr_vc + AX_CLAMP);
    thr_x = {1'b0, thr_u, 2'b00} + {3'b000, thr_u};
    if (thr_v < -THR_LOW_CUT) begin
      throttle_cmd = 10'd0;
    end else begin
      throttle_cmd = div18(thr_x);
    end
  end

  assign yaw_cmd   = map_axis(yaw_raw, cfg.yaw_center, 1'b0);
  assign pitch_cmd = map_axis(pitch_raw, cfg.pitch_center, 1'b1);
  assign roll_cmd  = map_axis(roll_raw, cfg.roll_center, 1'b0);

endmodule

// ===== sv/scea_arm_ctrl.sv =====
// ----------------------------------------------------------------------------
// scea_arm_ctrl
// Arming toggle with lockout, grace window, calibration hold and send timer.
// ----------------------------------------------------------------------------
module scea_arm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic           [31:0] time_ms,
  input  logic                  left_switch,
  input  logic                  right_switch,
  input  logic           [11:0] throttle_raw,
  input  logic           [11:0] yaw_raw,
  input  logic           [11:0] pitch_raw,
  input  logic           [11:0] roll_raw,
  input  scea_pkg::cfg_t        cfg,
  output scea_pkg::ctl_t        ctl
);
  import scea_pkg::*;

  logic        armed_r, armed_nxt;
  logic        prev_l_r;
  logic        prev_r_r;
  logic [31:0] last_tog_r, last_tog_nxt;
  logic [31:0] grace_end_r, grace_end_nxt;
  logic [31:0] hold_start_r, hold_start_nxt;
  logic        cal_fired_r, cal_fired_nxt;
  logic [31:0] last_send_r, last_send_nxt;

  logic              press;
  logic              toggle;
  logic              gesture;
  logic signed [13:0] th_s;
  logic              send;

  always_comb begin
    press  = (prev_l_r & ~left_switch) | (prev_r_r & ~right_switch);
    toggle = press && ((time_ms - last_tog_r) > LOCKOUT_MS);

    armed_nxt     = armed_r ^ toggle;
    last_tog_nxt  = toggle ? time_ms : last_tog_r;
    grace_end_nxt = grace_end_r;
    if (toggle) begin
      grace_end_nxt = armed_nxt ? (time_ms + GRACE_MS) : 32'd0;
    end

    th_s    = $signed({2'b00, cfg.gesture_thr});
    gesture = !armed_nxt &&
              ($signed({2'b00, throttle_raw}) < $signed({2'b00, cfg.thr_center}) - th_s) &&
              ($signed({2'b00, yaw_raw}) > $signed({2'b00, cfg.yaw_center}) + th_s) &&
              ($signed({2'b00, pitch_raw}) < $signed({2'b00, cfg.pitch_center}) - th_s) &&
              ($signed({2'b00, roll_raw}) < $signed({2'b00, cfg.roll_center}) - th_s);

    if (gesture) begin
      hold_start_nxt = (hold_start_r == 32'd0) ? time_ms : hold_start_r;
      cal_fired_nxt  = ((hold_start_r == 32'd0) ? 1'b0 : cal_fired_r) |
                       ((time_ms - hold_start_nxt) >= {16'd0, cfg.cal_hold_ms});
    end else begin
      hold_start_nxt = 32'd0;
      cal_fired_nxt  = 1'b0;
    end

    send          = (time_ms - last_send_r) >= SEND_MS;
    last_send_nxt = send ? time_ms : last_send_r;

    ctl.armed    = armed_nxt;
    ctl.cal      = cal_fired_nxt;
    ctl.thr_zero = !armed_nxt || (grace_end_nxt != 32'd0 && time_ms < grace_end_nxt);
    ctl.send     = send;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r      <= 1'b0;
      prev_l_r     <= 1'b1;
      prev_r_r     <= 1'b1;
      last_tog_r   <= 32'd0;
      grace_end_r  <= 32'd0;
      hold_start_r <= 32'd0;
      cal_fired_r  <= 1'b0;
      last_send_r  <= 32'd0;
    end else if (fire) begin
      armed_r      <= armed_nxt;
      prev_l_r     <= left_switch;
      prev_r_r     <= right_switch;
      last_tog_r   <= last_tog_nxt;
      grace_end_r  <= grace_end_nxt;
      hold_start_r <= hold_start_nxt;
      cal_fired_r  <= cal_fired_nxt;
      last_send_r  <= last_send_nxt;
    end
  end

  a_cal_only_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
    cal_fired_r |-> !armed_r)
    else $error("calibration flag set while armed");

  a_grace_only_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (grace_end_r != 32'd0) |-> armed_r)
    else $error("grace window open while disarmed");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(armed_r) && $stable(last_send_r))
    else $error("state changed without an item");

endmodule

// ===== sv/stick_command_encoder_with_arming_unit.sv =====
// ----------------------------------------------------------------------------
// stick_command_encoder_with_arming_unit
// Top level: sample register, stick mapping, arming control, result register.
// ----------------------------------------------------------------------------
// One result word per sample word, one sample per clock cycle sustained while
// out_tready keeps up. A sample is captured in an input register, mapped and
// combined with the arming state in a single pass (one reciprocal multiply per
// axis divides by 18), and the result moves into an output register once the
// output is free. While a result waits for out_tready, the input side keeps
// accepting only as long as the input register is free.
module stick_command_encoder_with_arming_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // time_ms[31:0], left_switch[32], right_switch[33], throttle_raw[45:34],
  // yaw_raw[57:46], pitch_raw[69:58], roll_raw[81:70], zero pad
  input  logic [scea_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // armed_flag[0], cal_level[1], throttle_cmd[11:2], yaw_cmd[21:12],
  // pitch_cmd[31:22], roll_cmd[41:32], send_packet[42], zero pad
  output logic [scea_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [scea_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scea_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import scea_pkg::*;

  in_item_t  in_r;
  logic      in_vld_r;
  out_item_t out_r, out_nxt;
  logic      out_vld_r;
  logic      fire;
  cfg_t      cfg;
  ctl_t      ctl;
  logic [9:0]        thr_map;
  logic signed [9:0] yaw_map, pitch_map, roll_map;

  assign fire      = in_vld_r & (~out_vld_r | out_tready);
  assign in_tready = ~in_vld_r | fire;

  scea_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scea_stick_map u_map (
    .throttle_raw (in_r.throttle_raw),
    .yaw_raw      (in_r.yaw_raw),
    .pitch_raw    (in_r.pitch_raw),
    .roll_raw     (in_r.roll_raw),
    .cfg          (cfg),
    .throttle_cmd (thr_map),
    .yaw_cmd      (yaw_map),
    .pitch_cmd    (pitch_map),
    .roll_cmd     (roll_map)
  );

  scea_arm_ctrl u_arm (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .time_ms      (in_r.time_ms),
    .left_switch  (in_r.left_switch),
    .right_switch (in_r.right_switch),
    .throttle_raw (in_r.throttle_raw),
    .yaw_raw      (in_r.yaw_raw),
    .pitch_raw    (in_r.pitch_raw),
    .roll_raw     (in_r.roll_raw),
    .cfg          (cfg),
    .ctl          (ctl)
  );

  always_comb begin
    out_nxt              = '0;
    out_nxt.armed_flag   = ctl.armed;
    out_nxt.cal_level    = ctl.cal;
    out_nxt.throttle_cmd = ctl.thr_zero ? 10'd0 : thr_map;
    out_nxt.yaw_cmd      = yaw_map;
    out_nxt.pitch_cmd    = pitch_map;
    out_nxt.roll_cmd     = roll_map;
    out_nxt.send_packet  = ctl.send;
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_r <= in_item_t'(in_tdata);
    end
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_vld_r <= 1'b1;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tdata  = out_r;
  assign out_tvalid = out_vld_r;

  a_thr_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.throttle_cmd != 10'd0) |-> out_r.armed_flag)
    else $error("throttle nonzero while disarmed");

  a_cal_needs_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.cal_level) |-> !out_r.armed_flag)
    else $error("calibrate raised while armed");

  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.throttle_cmd <= 10'd1000 &&
                   out_r.yaw_cmd <= 10'sd500 && out_r.yaw_cmd >= -10'sd500 &&
                   out_r.roll_cmd <= 10'sd500 && out_r.roll_cmd >= -10'sd500))
    else $error("command out of range");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> (out_vld_r && $stable(out_r)))
    else $error("pending result word lost");

endmodule
